// ===== rtl/core/mvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared constants for the multi-voice sample mixer: operation codes,
// field widths and default sizes.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	// Operation codes carried by an input word
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 17;
	localparam int MIX_W    = 20;
	localparam int BUSY_W   = 5;

	// Longest sound in sample pairs
	localparam logic [LEN_W-1:0] MAX_SOUND = 17'h10000;

	// Default sizes
	localparam int DEF_VOICE_COUNT  = 16;
	localparam int DEF_SAMPLE_DEPTH = 65536;

endpackage

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Stereo one-shot sample player with VOICE_COUNT voices sharing one
// sample memory port.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per operation:
//   write a left/right pair into sample memory, start a sound on the lowest
//   free voice, or tick (mix all active voices and advance them). Every
//   accepted word gives exactly one result word on the output channel
//   (out_valid / out_stall): status, the left/right totals and the number
//   of busy voices after the operation.
//   A start checks the voices for a free slot one per cycle; a tick walks
//   the voices one per cycle through the modulo and memory read pipeline,
//   four stages deep. One word is in work at a time; in_stall stays high
//   until its result is loaded into the output register.
//   A result waiting on out_stall holds its payload; a new word may be
//   accepted meanwhile and its result waits in the done state.
//   Reset clears all voices and the output valid; sample memory content is
//   undefined until written.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer #(
	parameter int VOICE_COUNT  = mvsm_pkg::DEF_VOICE_COUNT,
	parameter int SAMPLE_DEPTH = mvsm_pkg::DEF_SAMPLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mvsm_pkg::OP_W-1:0]           operation,
	input  logic [mvsm_pkg::ADDR_W-1:0]         address,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] right_in,
	input  logic [mvsm_pkg::LEN_W-1:0]          sound_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic signed [mvsm_pkg::MIX_W-1:0]   mix_left,
	output logic signed [mvsm_pkg::MIX_W-1:0]   mix_right,
	output logic [mvsm_pkg::BUSY_W-1:0]         voices_busy
);
	import mvsm_pkg::*;

	localparam int VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int BUSY_CNT_W = $clog2(VOICE_COUNT + 1);
	localparam int MEM_AW     = $clog2(SAMPLE_DEPTH);
	localparam int PAIR_W     = 2 * SAMPLE_W;
	localparam int RECIP_W    = 25;
	localparam int PROD_W     = ADDR_W + RECIP_W;
	localparam int QUOT_W     = 8;
	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);
	// Pointer modulo depth is needed only when the depth is below the pointer range
	localparam bit MOD_NEEDED = (SAMPLE_DEPTH < 65536);
	localparam logic [ADDR_W-1:0] DEPTH16 = ADDR_W'(SAMPLE_DEPTH);
	// ceil(2^32 / depth): exact quotient for any 16-bit pointer and depth >= 256
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << 32) + SAMPLE_DEPTH - 1) / SAMPLE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TICK, S_DONE} state_t;

	state_t                    state_q;
	logic [VOICE_COUNT-1:0]    active_q;
	logic [BUSY_CNT_W-1:0]     busy_q;
	logic [VIDX_W-1:0]         vidx_q;
	logic                      issuing_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [LEN_W-1:0]          len_q;
	logic                      status_q;
	logic signed [MIX_W-1:0]   sum_l_q;
	logic signed [MIX_W-1:0]   sum_r_q;

	logic                      out_valid_q;
	logic                      out_status_q;
	logic signed [MIX_W-1:0]   out_left_q;
	logic signed [MIX_W-1:0]   out_right_q;
	logic [BUSY_W-1:0]         out_busy_q;

	// Voice walk pipeline
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [VIDX_W-1:0]         idx_s1;
	logic [ADDR_W-1:0]         ptr_s1, ptr_s2;
	logic [LEN_W-1:0]          rem_s1;
	logic [PROD_W-1:0]         prod_s2;
	logic [ADDR_W-1:0]         r_s3;
	logic [PAIR_W-1:0]         pair_s4;

	// Voice pointer and remaining-count memories
	logic [ADDR_W-1:0]         ptr_mem [VOICE_COUNT];
	logic [LEN_W-1:0]          rem_mem [VOICE_COUNT];
	logic [PAIR_W-1:0]         sample_mem [SAMPLE_DEPTH];

	logic                      in_acc;
	logic                      mem_we;
	logic [LEN_W-1:0]          len_sat;
	logic                      scan_hit;
	logic                      tick_wb;
	logic [LEN_W-1:0]          rem_dec;
	logic                      vw_en;
	logic [VIDX_W-1:0]         vw_idx;
	logic [ADDR_W-1:0]         vw_ptr;
	logic [LEN_W-1:0]          vw_rem;
	logic [QUOT_W-1:0]         quot_s2;
	logic                      drained;
	logic                      out_free;

	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign mix_left    = out_left_q;
	assign mix_right   = out_right_q;
	assign voices_busy = out_busy_q;

	// Sample write on accept, inside the memory only
	assign mem_we  = in_acc && (operation == OP_WRITE) && (32'(address) < 32'(SAMPLE_DEPTH));
	assign len_sat = (sound_length > MAX_SOUND) ? MAX_SOUND : sound_length;

	// Voice state write port: start claims a slot, tick advances a voice
	assign scan_hit = (state_q == S_SCAN) && !active_q[vidx_q];
	assign tick_wb  = (state_q == S_TICK) && v_s1;
	assign rem_dec  = (rem_s1 != '0) ? rem_s1 - LEN_W'(1) : '0;
	assign vw_en    = scan_hit || tick_wb;
	assign vw_idx   = scan_hit ? vidx_q : idx_s1;
	assign vw_ptr   = scan_hit ? addr_q : ptr_s1 + ADDR_W'(1);
	assign vw_rem   = scan_hit ? len_q : rem_dec;

	assign quot_s2  = prod_s2[32 +: QUOT_W];
	assign drained  = !issuing_q && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign out_free = !out_valid_q || !out_stall;

	// Voice memories: one write, one read at the walk index
	always_ff @(posedge clk) begin
		if (vw_en) begin
			ptr_mem[vw_idx] <= vw_ptr;
			rem_mem[vw_idx] <= vw_rem;
		end
		ptr_s1 <= ptr_mem[vidx_q];
		rem_s1 <= rem_mem[vidx_q];
	end

	// Sample memory: write from input, registered read from the walk
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[MEM_AW'(address)] <= {left_in, right_in};
		end
		pair_s4 <= sample_mem[MEM_AW'(r_s3)];
	end

	// Walk datapath: pointer modulo depth by reciprocal multiply
	always_ff @(posedge clk) begin
		idx_s1  <= vidx_q;
		prod_s2 <= PROD_W'(ptr_s1) * PROD_W'(RECIP);
		ptr_s2  <= ptr_s1;
		r_s3    <= MOD_NEEDED ?
			ptr_s2 - ADDR_W'(24'(quot_s2) * 24'(DEPTH16)) : ptr_s2;
	end

	// Sequencer, voice flags, totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= '0;
			busy_q       <= '0;
			vidx_q       <= '0;
			issuing_q    <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			out_valid_q  <= 1'b0;
			addr_q       <= '0;
			len_q        <= '0;
			status_q     <= 1'b0;
			sum_l_q      <= '0;
			sum_r_q      <= '0;
			out_status_q <= 1'b0;
			out_left_q   <= '0;
			out_right_q  <= '0;
			out_busy_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// pipeline valids
			v_s1 <= (state_q == S_TICK) && issuing_q && active_q[vidx_q];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			// retire a voice at its last pair
			if (tick_wb && (rem_dec == '0)) begin
				active_q[idx_s1] <= 1'b0;
				busy_q           <= busy_q - BUSY_CNT_W'(1);
			end

			// accumulate the fetched pair
			if (v_s4) begin
				sum_l_q <= sum_l_q + MIX_W'(signed'(pair_s4[PAIR_W-1 -: SAMPLE_W]));
				sum_r_q <= sum_r_q + MIX_W'(signed'(pair_s4[SAMPLE_W-1:0]));
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= 1'b0;
						sum_l_q  <= '0;
						sum_r_q  <= '0;
						vidx_q   <= '0;
						addr_q   <= address;
						len_q    <= len_sat;
						if (operation == OP_START && len_sat != '0) begin
							state_q <= S_SCAN;
						end else if (operation == OP_TICK) begin
							issuing_q <= 1'b1;
							state_q   <= S_TICK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						active_q[vidx_q] <= 1'b1;
						busy_q           <= busy_q + BUSY_CNT_W'(1);
						state_q          <= S_DONE;
					end else if (vidx_q == LAST_VOICE) begin
						status_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						vidx_q <= vidx_q + VIDX_W'(1);
					end
				end
				S_TICK: begin
					if (issuing_q) begin
						if (vidx_q == LAST_VOICE) begin
							issuing_q <= 1'b0;
						end else begin
							vidx_q <= vidx_q + VIDX_W'(1);
						end
					end else if (drained) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_left_q   <= sum_l_q;
						out_right_q  <= sum_r_q;
						out_busy_q   <= BUSY_W'(busy_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Busy count never exceeds the number of voices
	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q <= BUSY_CNT_W'(VOICE_COUNT))
		else $error("busy count above voice count");

	// Busy count tracks the active flags
	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_q) == int'(busy_q))
		else $error("busy count out of step with active voices");

	// Walk pipeline only runs during a tick
	a_walk_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3 || v_s4) |-> (state_q == S_TICK))
		else $error("walk pipeline busy outside tick");

	// A tick starts from cleared totals
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && operation == OP_TICK) |=> (sum_l_q == '0 && sum_r_q == '0))
		else $error("totals not cleared on tick");

endmodule

// ===== verif/multi_voice_sample_mixer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_test
// Self-checking bench for the stereo sample mixer. Words are driven through
// the valid/stall input channel, each accepted word is predicted by a voice
// model kept in a scoreboard, and every result word is checked field by
// field. Sounds are only ever ticked over sample entries that were written.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_test;
	import mvsm_pkg::*;

	localparam int VOICES       = DEF_VOICE_COUNT;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int TOTAL_WORDS  = 1400;
	// encoding left unused by the block
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic              status;
		logic [MIX_W-1:0]  mix_left;
		logic [MIX_W-1:0]  mix_right;
		logic [BUSY_W-1:0] voices_busy;
	} mix_word_t;

	// Voice model plus the queue of result words still to come
	class mix_scoreboard;
		bit [31:0]       pair_mem [65536];
		bit              pair_written [65536];
		bit              voice_on [VOICES];
		bit [ADDR_W-1:0] voice_ptr [VOICES];
		bit [LEN_W-1:0]  voice_left [VOICES];
		mix_word_t       expected_q [$];
		int              fails;

		function int pending();
			return expected_q.size();
		endfunction

		function void note_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
				logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic [LEN_W-1:0] len);
			mix_word_t      res;
			int             sum_l;
			int             sum_r;
			int             busy;
			int             v;
			bit             placed;
			bit [LEN_W-1:0] n;
			bit [31:0]      pair;
			res = '0;
			sum_l = 0;
			sum_r = 0;
			busy = 0;
			placed = 0;
			n = len;
			case (op)
				OP_WRITE: begin
					pair_mem[addr] = {l, r};
					pair_written[addr] = 1'b1;
				end
				OP_START: begin
					if (n > MAX_SOUND)
						n = MAX_SOUND;
					// zero length takes no voice and is not a drop
					if (n != 0) begin
						for (v = 0; v < VOICES; v++) begin
							if (!placed && !voice_on[v]) begin
								voice_on[v] = 1'b1;
								voice_ptr[v] = addr;
								voice_left[v] = n;
								placed = 1'b1;
							end
						end
						res.status = !placed;
					end
				end
				OP_TICK: begin
					for (v = 0; v < VOICES; v++) begin
						if (voice_on[v]) begin
							pair = pair_mem[voice_ptr[v]];
							sum_l += $signed(pair[31:16]);
							sum_r += $signed(pair[15:0]);
							voice_ptr[v] = voice_ptr[v] + 1'b1;
							if (voice_left[v] != 0)
								voice_left[v] = voice_left[v] - 1'b1;
							if (voice_left[v] == 0)
								voice_on[v] = 1'b0;
						end
					end
				end
				default: ;
			endcase
			for (v = 0; v < VOICES; v++)
				busy += voice_on[v];
			res.mix_left = sum_l[MIX_W-1:0];
			res.mix_right = sum_r[MIX_W-1:0];
			res.voices_busy = busy[BUSY_W-1:0];
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				fails++;
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic st, logic [MIX_W-1:0] ml, logic [MIX_W-1:0] mr,
				logic [BUSY_W-1:0] busy);
			mix_word_t want;
			if (expected_q.size() == 0) begin
				fails++;
				$display("%0t ns: result word with nothing expected, expected none, got %0d %0d %0d %0d",
					$time, st, $signed(ml), $signed(mr), busy);
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", want.status, st);
			compare_field("mix_left", $signed(want.mix_left), $signed(ml));
			compare_field("mix_right", $signed(want.mix_right), $signed(mr));
			compare_field("voices_busy", want.voices_busy, busy);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       operation = OP_WRITE;
	logic [ADDR_W-1:0]     address = '0;
	logic [SAMPLE_W-1:0]   left_in = '0;
	logic [SAMPLE_W-1:0]   right_in = '0;
	logic [LEN_W-1:0]      sound_length = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  status;
	logic [MIX_W-1:0]      mix_left;
	logic [MIX_W-1:0]      mix_right;
	logic [BUSY_W-1:0]     voices_busy;

	mix_scoreboard sb;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            words_sent = 0;
	int            hold_asked = 0;
	int            hold_taken = 0;
	int            hold_cnt = 0;
	logic [ADDR_W-1:0] burst_base_q [$];
	int                burst_size_q [$];

	multi_voice_sample_mixer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.address      (address),
		.left_in      (left_in),
		.right_in     (right_in),
		.sound_length (sound_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.mix_left     (mix_left),
		.mix_right    (mix_right),
		.voices_busy  (voices_busy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: check accepted words, then choose next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, mix_left, mix_right, voices_busy);
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: too long without any word moving on either side
	initial begin
		int stuck;
		stuck = 0;
		@(posedge arst_n);
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offer one word, with random idle cycles first, and note it once taken
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
			input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		left_in <= l;
		right_in <= r;
		sound_length <= len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(op, addr, l, r, len);
		if (op != OP_NONE)
			words_sent++;
	endtask

	task automatic put_pair(input logic [ADDR_W-1:0] addr);
		send_word(OP_WRITE, addr, 16'($urandom), 16'($urandom), 17'($urandom));
	endtask

	// Tick, after filling any entry an active voice is about to read
	task automatic tick_mix();
		int v;
		for (v = 0; v < VOICES; v++) begin
			if (sb.voice_on[v] && !sb.pair_written[sb.voice_ptr[v]])
				put_pair(sb.voice_ptr[v]);
		end
		send_word(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom));
	endtask

	// Mostly lengths inside the written span, rarely zero or very long
	function automatic logic [LEN_W-1:0] sound_len(int span);
		int r;
		r = $urandom_range(999);
		if (r < 10)
			return '0;
		if (r < 13)
			return MAX_SOUND;
		if (r < 16)
			return 17'($urandom_range(131071, 65537));
		return 17'($urandom_range(span, 1));
	endfunction

	task automatic start_known();
		int k;
		if (burst_base_q.size() == 0) begin
			send_word(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), sound_len(8));
		end else begin
			k = $urandom_range(burst_base_q.size() - 1);
			send_word(OP_START, burst_base_q[k], 16'($urandom), 16'($urandom),
				sound_len(burst_size_q[k]));
		end
	endtask

	task automatic random_step();
		int r;
		int n;
		int i;
		logic [ADDR_W-1:0] base;
		r = $urandom_range(99);
		if (r < 22) begin
			// block of pairs, then a sound over it
			base = 16'($urandom);
			n = $urandom_range(24, 4);
			for (i = 0; i < n; i++)
				put_pair(base + 16'(i));
			burst_base_q.push_back(base);
			burst_size_q.push_back(n);
			if (burst_base_q.size() > 32) begin
				void'(burst_base_q.pop_front());
				void'(burst_size_q.pop_front());
			end
			send_word(OP_START, base, 16'($urandom), 16'($urandom), sound_len(n));
		end else if (r < 55) begin
			tick_mix();
		end else if (r < 68) begin
			start_known();
		end else if (r < 76) begin
			// several starts in a row to run out of voices
			n = $urandom_range(8, 3);
			for (i = 0; i < n; i++)
				start_known();
		end else if (r < 84) begin
			put_pair(16'($urandom));
		end else if (r < 89) begin
			send_word(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom));
		end else begin
			n = $urandom_range(12, 3);
			for (i = 0; i < n; i++)
				tick_mix();
		end
	endtask

	initial begin
		int p;
		int i;
		int idle_tab [4];
		int stall_tab [4];
		idle_tab = '{0, 56, 0, 27};
		stall_tab = '{0, 0, 56, 27};
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme samples, pointer wrap, zero and overlong length,
		// unused operation, all voices busy, a drop, extreme totals
		send_word(OP_WRITE, 16'hFFFF, 16'h7FFF, 16'h8000, '0);
		send_word(OP_WRITE, 16'h0000, 16'h8000, 16'h8000, '0);
		send_word(OP_WRITE, 16'h0001, 16'h7FFF, 16'h7FFF, '0);
		send_word(OP_START, 16'hFFFF, '0, '0, 17'h1FFFF);
		send_word(OP_START, 16'h0000, '0, '0, '0);
		send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
		for (i = 0; i < VOICES - 1; i++)
			send_word(OP_START, 16'h0000, '0, '0, 17'd2);
		send_word(OP_START, 16'h0001, '0, '0, 17'd1);
		tick_mix();
		tick_mix();

		// Random phases with different idle and stall mixes
		for (p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			if (p == 0) begin
				// long receiver hold while words keep coming
				hold_asked++;
				for (i = 0; i < 6; i++)
					random_step();
			end
			while (words_sent < 24 + (p + 1) * ((TOTAL_WORDS - 24) / 4))
				random_step();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
